// File: rtl/rrbc_pkg.sv
// Shared constants, types and helper functions of the ROM/RAM bank controller.
`default_nettype none

package rrbc_pkg;

  localparam int RAM_BANK_COUNT = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BITS  = 7;

  localparam int STORE_BYTES = RAM_BANK_COUNT * RAM_BANK_BYTES;
  localparam int RAM_IDX_W    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int RAM_OFS_W    = $clog2(RAM_BANK_BYTES);
  localparam int ROM_ADDR_W   = 21;
  localparam int ROM_OFS_W    = 14;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_CTRL_WR = 2'd0;
  localparam logic [1:0] MODE_ROM_RD  = 2'd1;
  localparam logic [1:0] MODE_RAM_WR  = 2'd2;
  localparam logic [1:0] MODE_RAM_RD  = 2'd3;

  localparam logic [2:0] REGION_RAM_EN_LO = 3'd0;
  localparam logic [2:0] REGION_RAM_EN_HI = 3'd1;
  localparam logic [2:0] REGION_BANK_LO_A = 3'd2;
  localparam logic [2:0] REGION_BANK_LO_B = 3'd3;
  localparam logic [2:0] REGION_BANK_HI_A = 3'd4;
  localparam logic [2:0] REGION_BANK_HI_B = 3'd5;
  localparam logic [2:0] REGION_MODE_A    = 3'd6;
  localparam logic [2:0] REGION_MODE_B    = 3'd7;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  typedef struct packed {
    logic                  is_read;
    logic                  ram_we;
    logic [RAM_IDX_W-1:0]  ram_idx;
    logic [7:0]            write_data;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  rom_hit;
  } op_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  rom_hit;
    logic                  ram_write_done;
  } res_t;

  function automatic logic [ROM_BANK_BITS-1:0] fix_rom_bank(input logic [6:0] bank_in);
    logic [ROM_BANK_BITS-1:0] bank;
    bank = bank_in[ROM_BANK_BITS-1:0];
    if (bank[4:0] == 5'd0) begin
      bank = bank + ROM_BANK_BITS'(1);
    end
    return bank;
  endfunction

  function automatic logic [1:0] wrap_ram_bank(input logic [1:0] bank_in);
    logic [2:0] bank;
    bank = {1'b0, bank_in};
    if (bank >= 3'(RAM_BANK_COUNT)) begin
      bank = bank - 3'(RAM_BANK_COUNT);
    end
    if (bank >= 3'(RAM_BANK_COUNT)) begin
      bank = bank - 3'(RAM_BANK_COUNT);
    end
    if (bank >= 3'(RAM_BANK_COUNT)) begin
      bank = bank - 3'(RAM_BANK_COUNT);
    end
    return bank[1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/rrbc_front.sv
// Front end: accepts bus accesses, holds the banking registers and classifies each access.
`default_nettype none

module rrbc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire logic [1:0]      in_mode,
  input  wire logic [15:0]     in_address,
  input  wire logic [7:0]      in_write_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output rrbc_pkg::op_t        q_op
);
  import rrbc_pkg::*;

  logic                     ram_enable_r, ram_enable_nxt;
  logic [ROM_BANK_BITS-1:0] rom_bank_r, rom_bank_nxt;
  logic [1:0]               ram_bank_r, ram_bank_nxt;
  logic                     bank_mode_r, bank_mode_nxt;
  logic [1:0]               ram_bank_w;
  logic [ROM_BANK_BITS-1:0] rom_bank_sel;

  assign q_push = in_push && !q_full;

  always_comb begin
    ram_enable_nxt = ram_enable_r;
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    bank_mode_nxt  = bank_mode_r;
    if (q_push && (in_mode == MODE_CTRL_WR) && !in_address[15]) begin
      case (in_address[14:12])
        REGION_RAM_EN_LO, REGION_RAM_EN_HI: begin
          ram_enable_nxt = (in_write_data[3:0] == RAM_ENABLE_KEY);
        end
        REGION_BANK_LO_A, REGION_BANK_LO_B: begin
          rom_bank_nxt = fix_rom_bank({2'b00, in_write_data[4:0]});
        end
        REGION_BANK_HI_A, REGION_BANK_HI_B: begin
          if (!bank_mode_r) begin
            rom_bank_nxt = fix_rom_bank({in_write_data[1:0], rom_bank_r[4:0]});
          end else begin
            ram_bank_nxt = in_write_data[1:0];
          end
        end
        REGION_MODE_A, REGION_MODE_B: begin
          bank_mode_nxt = in_write_data[0];
          if (!in_write_data[0]) begin
            ram_bank_nxt = 2'd0;
          end
        end
        default: begin
          ram_enable_nxt = ram_enable_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      rom_bank_r   <= ROM_BANK_BITS'(1);
      ram_bank_r   <= 2'd0;
      bank_mode_r  <= 1'b0;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      bank_mode_r  <= bank_mode_nxt;
    end
  end

  assign ram_bank_w   = wrap_ram_bank(ram_bank_r);
  assign rom_bank_sel = in_address[14] ? rom_bank_r : '0;

  always_comb begin
    q_op             = '0;
    q_op.write_data  = in_write_data;
    q_op.ram_idx     = RAM_IDX_W'({ram_bank_w, in_address[RAM_OFS_W-1:0]});
    q_op.is_read     = (in_mode == MODE_RAM_RD);
    q_op.ram_we      = (in_mode == MODE_RAM_WR) && ram_enable_r;
    if ((in_mode == MODE_ROM_RD) && !in_address[15]) begin
      q_op.rom_hit     = 1'b1;
      q_op.rom_address = (ROM_ADDR_W'(rom_bank_sel) << ROM_OFS_W)
                         | ROM_ADDR_W'(in_address[ROM_OFS_W-1:0]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/rrbc_queue.sv
// Short queue of classified accesses between the front end and the back end.
`default_nettype none

module rrbc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rrbc_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output rrbc_pkg::op_t      head_op
);
  import rrbc_pkg::*;

  op_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head_op = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rrbc_back.sv
// Back end: banked RAM store access, result assembly and the result buffer.
`default_nettype none

module rrbc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire rrbc_pkg::op_t q_op,
  output logic               q_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output rrbc_pkg::res_t     out_res
);
  import rrbc_pkg::*;

  logic [7:0]        ram_mem [STORE_BYTES];
  logic [7:0]        mem_q_r;
  logic              s1_valid_r;
  logic              s1_is_read_r;
  logic              s1_done_r;
  logic [ROM_ADDR_W-1:0] s1_rom_address_r;
  logic              s1_rom_hit_r;

  res_t              buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QCNT_W:0]   in_flight;
  logic              out_fire;
  res_t              s1_res;

  assign out_empty = (count_r == '0);
  assign out_res   = buf_r[rd_ptr_r];
  assign out_fire  = out_pop && !out_empty;

  assign in_flight = (QCNT_W+1)'(count_r) + (QCNT_W+1)'(s1_valid_r)
                     - (QCNT_W+1)'(out_fire);
  assign q_pop     = q_valid && (in_flight < (QCNT_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (q_pop && q_op.ram_we) begin
      ram_mem[q_op.ram_idx] <= q_op.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q_r <= ram_mem[q_op.ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_is_read_r     <= q_op.is_read;
      s1_done_r        <= q_op.ram_we;
      s1_rom_address_r <= q_op.rom_address;
      s1_rom_hit_r     <= q_op.rom_hit;
    end
  end

  always_comb begin
    s1_res.read_data      = s1_is_read_r ? mem_q_r : 8'd0;
    s1_res.rom_address    = s1_rom_address_r;
    s1_res.rom_hit        = s1_rom_hit_r;
    s1_res.ram_write_done = s1_done_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (s1_valid_r && !out_fire) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (out_fire && !s1_valid_r) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= q_pop;
      count_r    <= count_nxt;
      if (s1_valid_r) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      buf_r[wr_ptr_r] <= s1_res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rom_ram_bank_controller_core.sv
// Top level of the cartridge ROM/RAM bank controller.
//
// Bus accesses enter through a queue-style port: a transaction is taken when
// in_push is high and in_full is low. Each access gives exactly one result,
// delivered in order on a queue-style output: the oldest result is shown while
// out_empty is low and is taken when out_pop is high.
// Mode 0 writes the banking registers, mode 1 maps a ROM read to a physical
// ROM byte address, modes 2 and 3 write and read the banked 32 KiB RAM store.
// A taken access is registered in the queue, then in the back end's RAM read
// stage, then in the result buffer, from which its result is shown.
// One access per cycle is sustained while the receiver keeps out_pop high; the
// single-port RAM read and write in the back end sets that figure.
// Reset restores RAM disabled, ROM bank 1, RAM bank 0 and banking mode 0, and
// empties both queues; the RAM contents are not cleared and a location must be
// written before it is read.
// When the receiver stalls, results collect in a two-entry buffer, then in the
// two-entry queue behind the front end, after which in_full rises.
`default_nettype none

module rom_ram_bank_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_read_data,
  output logic [20:0]      out_rom_address,
  output logic             out_rom_hit,
  output logic             out_ram_write_done
);
  import rrbc_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  op_t  push_op, head_op;
  res_t res;

  rrbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (push_op)
  );

  rrbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  rrbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign in_full            = q_full;
  assign out_read_data      = res.read_data;
  assign out_rom_address    = res.rom_address;
  assign out_rom_hit        = res.rom_hit;
  assign out_ram_write_done = res.ram_write_done;

endmodule

`default_nettype wire

// File: rtl/rrbc_checker.sv
// Port-level checker for the bank controller, bound to the top level.
`default_nettype none

module rrbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [7:0]  out_read_data,
  input wire logic [20:0] out_rom_address,
  input wire logic        out_rom_hit,
  input wire logic        out_ram_write_done
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("Queues not empty after reset.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_read_data)
      && $stable(out_rom_address) && $stable(out_rom_hit) && $stable(out_ram_write_done))
    else $error("Stalled result changed.");

  a_rom_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_rom_hit |-> out_read_data == 8'd0 && !out_ram_write_done)
    else $error("ROM result carries RAM fields.");

  a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_ram_write_done |-> out_read_data == 8'd0 && !out_rom_hit
      && out_rom_address == 21'd0)
    else $error("RAM write result carries other fields.");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_rom_hit |-> out_rom_address == 21'd0)
    else $error("ROM address without a ROM hit.");

endmodule

bind rom_ram_bank_controller_core rrbc_checker u_rrbc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_read_data      (out_read_data),
  .out_rom_address    (out_rom_address),
  .out_rom_hit        (out_rom_hit),
  .out_ram_write_done (out_ram_write_done)
);

`default_nettype wire
